@@ design/ifdc_pkg.sv @@
// Shared constants, codes and helper functions of the inverter CAN frame decoder.
`default_nettype none

package ifdc_pkg;

	// Frame identifiers.
	localparam logic [10:0] ID_SPEED_A  = 11'h1DA;
	localparam logic [10:0] ID_SPEED_B  = 11'h01A;
	localparam logic [10:0] ID_TORQUE_A = 11'h1DB;
	localparam logic [10:0] ID_TORQUE_B = 11'h01B;
	localparam logic [10:0] ID_TEMPS_A  = 11'h1DC;
	localparam logic [10:0] ID_TEMPS_B  = 11'h01C;
	localparam logic [10:0] ID_TEMPS_V  = 11'h55A;
	localparam logic [10:0] ID_STATUS_A = 11'h1D4;
	localparam logic [10:0] ID_STATUS_B = 11'h014;

	// Frame kind codes reported on the result word.
	localparam logic [2:0] KIND_IGNORED      = 3'd0;
	localparam logic [2:0] KIND_SPEED        = 3'd1;
	localparam logic [2:0] KIND_SPEED_TORQUE = 3'd2;
	localparam logic [2:0] KIND_TORQUE       = 3'd3;
	localparam logic [2:0] KIND_TEMPS        = 3'd4;
	localparam logic [2:0] KIND_STATUS       = 3'd5;

	// Configuration register indexes.
	localparam logic REG_TEMPS_EN     = 1'b0;
	localparam logic REG_TORQUE_BIAS  = 1'b1;

	// Frame counter slots.
	localparam logic [1:0] CNT_SPEED  = 2'd0;
	localparam logic [1:0] CNT_TORQUE = 2'd1;
	localparam logic [1:0] CNT_TEMPS  = 2'd2;
	localparam logic [1:0] CNT_STATUS = 2'd3;

	// Scaling constants.
	localparam logic signed [17:0] TORQUE_LIMIT = 18'sd50000;
	localparam logic signed [17:0] STEP_18      = 18'sd50;
	localparam logic signed [21:0] STEP_22      = 22'sd50;
	localparam logic [8:0]         TEMP_OFFSET  = 9'd40;
	localparam logic signed [8:0]  BIAS_RESET   = -9'sd64;

	// Word widths.
	localparam int IN_W   = 80;
	localparam int OUT_W  = 128;

	// Legacy torque: 16-bit little-endian word of bytes two and three, or of
	// bytes zero and one when the former is zero and the latter is not.
	function automatic logic signed [21:0] legacy_torque(input logic [63:0] data);
		logic [15:0] w01;
		logic [15:0] w23;
		logic [15:0] pick;
		w01  = data[15:0];
		w23  = data[31:16];
		pick = (w23 != 16'd0 || w01 == 16'd0) ? w23 : w01;
		return $signed({{6{pick[15]}}, pick}) * STEP_22;
	endfunction

	// Temperature byte with the forty degree offset removed.
	function automatic logic signed [8:0] temp_of(input logic [7:0] b);
		return $signed({1'b0, b} - TEMP_OFFSET);
	endfunction

endpackage

`default_nettype wire

@@ design/inverter_can_frame_decoder_core.sv @@
// Top level of the inverter CAN frame decoder: input register, decode and held feedback.
`default_nettype none

// One received CAN frame goes in per word and one result word comes out per
// frame. A frame is captured in an input register, decoded from it by field
// slicing, two small constant multiplies and compares, and the result word
// is then registered in a result register. The block takes a new frame every
// cycle; the two pipeline registers only hold when the result word is not
// taken, so a frame can still enter while one result waits.
// Configuration writes are always accepted and take effect on any frame that
// is decoded after the write, including one held in the input register.
module inverter_can_frame_decoder_core
	import ifdc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Frame input. tdata: can_id[10:0], frame_length[14:11], frame_data[78:15], zeros.
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	// Result output. tdata: motor_rpm[14:0], torque_centi_nm[36:15],
	// input_volts[45:37], inverter_celsius[54:46], stator_celsius[63:55],
	// coolant_celsius[72:64], status_flags[76:73], motor_clock[78:77],
	// motor_errors[84:79], speed_crc_byte[92:85], kind_count[124:93], zeros.
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,
	// Result tuser: frame_kind[2:0].
	output logic [2:0]            m_tuser,
	// Configuration write channel.
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [8:0]       cfg_data
);

	// Configuration registers.
	logic              temps_en_q;
	logic signed [8:0] bias_q;

	// Input stage.
	logic        valid_s1;
	logic [10:0] id_s1;
	logic [3:0]  len_s1;
	logic [63:0] data_s1;

	// Held feedback and counters.
	logic signed [14:0] rpm_q;
	logic signed [21:0] torque_q;
	logic [8:0]         volts_q;
	logic signed [8:0]  temps_q [3];
	logic [3:0]         flags_q;
	logic [15:0]        cec_q;
	logic [31:0]        counters_q [4];

	// Result register.
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [31:0] count_q;

	// Decode results.
	logic               advance;
	logic [2:0]         kind_d;
	logic [31:0]        count_d;
	logic               upd_speed;
	logic               upd_full;
	logic               upd_torque;
	logic               upd_temps;
	logic               temps_variant;
	logic               upd_status;
	logic [10:0]        t11;
	logic signed [17:0] prim;
	logic               prim_ok;
	logic signed [21:0] torque_full;
	logic signed [21:0] torque_legacy;
	logic [31:0]        cnt_speed_inc;
	logic [31:0]        cnt_torque_inc;
	logic [31:0]        cnt_temps_inc;
	logic [31:0]        cnt_status_inc;

	// Both stages move together whenever the result word is free or taken.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temps_en_q <= 1'b0;
			bias_q     <= BIAS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMPS_EN:    temps_en_q <= cfg_data[0];
				REG_TORQUE_BIAS: bias_q     <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			id_s1   <= s_tdata[10:0];
			len_s1  <= s_tdata[14:11];
			data_s1 <= s_tdata[78:15];
		end
	end

	// Torque decode: primary field with bias, legacy word as fallback.
	assign t11           = {data_s1[18:16], data_s1[31:24]};
	assign prim          = $signed({{7{t11[10]}}, t11}) * STEP_18 + {{9{bias_q[8]}}, bias_q};
	assign prim_ok       = (prim <= TORQUE_LIMIT) && (prim >= -TORQUE_LIMIT);
	assign torque_legacy = legacy_torque(data_s1);
	assign torque_full   = prim_ok ? {{4{prim[17]}}, prim} : torque_legacy;

	assign cnt_speed_inc  = counters_q[CNT_SPEED] + 32'd1;
	assign cnt_torque_inc = counters_q[CNT_TORQUE] + 32'd1;
	assign cnt_temps_inc  = counters_q[CNT_TEMPS] + 32'd1;
	assign cnt_status_inc = counters_q[CNT_STATUS] + 32'd1;

	// Frame classification by identifier and length.
	always_comb begin
		upd_speed     = 1'b0;
		upd_full      = 1'b0;
		upd_torque    = 1'b0;
		upd_temps     = 1'b0;
		temps_variant = 1'b0;
		upd_status    = 1'b0;
		kind_d        = KIND_IGNORED;
		count_d       = 32'd0;
		if (id_s1 == ID_SPEED_A || id_s1 == ID_SPEED_B) begin
			if (len_s1 >= 4'd4) begin
				upd_speed = 1'b1;
				upd_full  = len_s1 >= 4'd8;
				kind_d    = upd_full ? KIND_SPEED_TORQUE : KIND_SPEED;
				count_d   = cnt_speed_inc;
			end
		end else if (id_s1 == ID_TORQUE_A || id_s1 == ID_TORQUE_B) begin
			if (len_s1 >= 4'd4) begin
				upd_torque = 1'b1;
				kind_d     = KIND_TORQUE;
				count_d    = cnt_torque_inc;
			end
		end else if (id_s1 == ID_TEMPS_A || id_s1 == ID_TEMPS_B) begin
			if (len_s1 >= 4'd3) begin
				upd_temps = 1'b1;
				kind_d    = KIND_TEMPS;
				count_d   = cnt_temps_inc;
			end
		end else if (id_s1 == ID_TEMPS_V && temps_en_q) begin
			if (len_s1 >= 4'd4) begin
				upd_temps     = 1'b1;
				temps_variant = 1'b1;
				kind_d        = KIND_TEMPS;
				count_d       = cnt_temps_inc;
			end
		end else if (id_s1 == ID_STATUS_A || id_s1 == ID_STATUS_B) begin
			if (len_s1 != 4'd0) begin
				upd_status = 1'b1;
				kind_d     = KIND_STATUS;
				count_d    = cnt_status_inc;
			end
		end
	end

	// Held feedback and frame counters, updated as a frame leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_q      <= '0;
			torque_q   <= '0;
			volts_q    <= '0;
			temps_q[0] <= '0;
			temps_q[1] <= '0;
			temps_q[2] <= '0;
			flags_q    <= '0;
			cec_q      <= '0;
			counters_q[CNT_SPEED]  <= '0;
			counters_q[CNT_TORQUE] <= '0;
			counters_q[CNT_TEMPS]  <= '0;
			counters_q[CNT_STATUS] <= '0;
		end else if (valid_s1 && advance) begin
			if (upd_speed) begin
				rpm_q   <= $signed({data_s1[39:32], data_s1[47:41]});
				volts_q <= {data_s1[7:0], 1'b0};
				counters_q[CNT_SPEED] <= cnt_speed_inc;
			end
			if (upd_full) begin
				torque_q <= torque_full;
				cec_q    <= data_s1[63:48];
			end
			if (upd_torque) begin
				torque_q <= torque_legacy;
			end
			if (upd_full || upd_torque) begin
				counters_q[CNT_TORQUE] <= cnt_torque_inc;
			end
			if (upd_temps) begin
				if (temps_variant) begin
					temps_q[0] <= temp_of(data_s1[15:8]);
					temps_q[1] <= temp_of(data_s1[23:16]);
					temps_q[2] <= temp_of(data_s1[31:24]);
				end else begin
					temps_q[0] <= temp_of(data_s1[7:0]);
					temps_q[1] <= temp_of(data_s1[15:8]);
					temps_q[2] <= temp_of(data_s1[23:16]);
				end
				counters_q[CNT_TEMPS] <= cnt_temps_inc;
			end
			if (upd_status) begin
				flags_q <= data_s1[3:0];
				counters_q[CNT_STATUS] <= cnt_status_inc;
			end
		end
	end

	// Result register; held values stay put while the word waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= KIND_IGNORED;
			count_q     <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				kind_q  <= kind_d;
				count_q <= count_d;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {3'd0, count_q, cec_q[15:8], cec_q[7:2], cec_q[1:0], flags_q,
		temps_q[2], temps_q[1], temps_q[0], volts_q, torque_q, rpm_q};

`ifndef SYNTHESIS
	// An ignored frame reports a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_IGNORED) |-> (count_q == 32'd0))
		else $error("ignored frame reported a nonzero count");

	// Only defined kinds reach the result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= KIND_STATUS))
		else $error("undefined frame kind on result word");

	// A frame leaving stage one always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("decoded frame lost between stages");

	// Input is refused only when both stages are full and the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input refused without a full pipeline");

	// A bias write takes effect on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == REG_TORQUE_BIAS) |=> (bias_q == $signed($past(cfg_data))))
		else $error("torque bias write not applied");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the inverter CAN frame decoder: random and directed frames.
module testbench
	import ifdc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TORQUE_STEP  = 50;
	localparam int TORQUE_CAP   = 50000;
	localparam int PHASE_FRAMES = 206;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 300000;

	// Identifiers that the decoder knows, used to aim most random frames.
	localparam logic [10:0] KNOWN_IDS [9] = '{ID_SPEED_A, ID_SPEED_B, ID_TORQUE_A,
		ID_TORQUE_B, ID_TEMPS_A, ID_TEMPS_B, ID_TEMPS_V, ID_STATUS_A, ID_STATUS_B};

	// One expected result word, split into its fields.
	typedef struct {
		logic [2:0]  kind;
		logic [14:0] rpm;
		logic [21:0] torque;
		logic [8:0]  volts;
		logic [8:0]  inverter_c;
		logic [8:0]  stator_c;
		logic [8:0]  coolant_c;
		logic [3:0]  flags;
		logic [1:0]  rolling_clock;
		logic [5:0]  error_code;
		logic [7:0]  crc;
		logic [31:0] count;
	} feedback_t;

	// Scoreboard: keeps its own copy of the held feedback and the frame counters,
	// predicts the result word of every accepted frame and checks the words seen.
	class feedback_scoreboard;
		bit          temps_variant_on;
		int          torque_bias;
		logic [14:0] speed_rpm;
		int          torque_centi;
		logic [8:0]  supply_volts;
		logic [8:0]  celsius [3];
		logic [3:0]  status_bits;
		logic [15:0] speed_diag;
		logic [31:0] kind_counters [4];
		feedback_t   expected_feedback [$];
		int          mismatches;

		function new();
			temps_variant_on = 1'b0;
			torque_bias = -64;
			speed_rpm = '0;
			torque_centi = 0;
			supply_volts = '0;
			status_bits = '0;
			speed_diag = '0;
			mismatches = 0;
			foreach (celsius[i])
				celsius[i] = '0;
			foreach (kind_counters[i])
				kind_counters[i] = '0;
		endfunction

		function void write_reg(logic idx, logic [8:0] val);
			if (idx == REG_TEMPS_EN)
				temps_variant_on = val[0];
			else
				torque_bias = int'($signed(val));
		endfunction

		function int feedback_pending();
			return expected_feedback.size();
		endfunction

		// Old style torque pick: word of bytes two and three, or of bytes zero and
		// one when the upper word is zero and the lower one is not.
		function int legacy_centi(logic [63:0] data);
			logic [15:0] pick;
			pick = (data[31:16] != 16'd0 || data[15:0] == 16'd0) ? data[31:16] : data[15:0];
			return int'($signed(pick)) * TORQUE_STEP;
		endfunction

		function void note_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data);
			feedback_t   fb;
			logic [7:0]  b [8];
			logic [10:0] raw11;
			int          primary;
			int          magnitude;
			int          first;
			bit          temps_hit;
			fb.kind = KIND_IGNORED;
			fb.count = '0;
			temps_hit = 1'b0;
			first = 0;
			for (int k = 0; k < 8; k++)
				b[k] = data[8*k +: 8];

			if (id == ID_SPEED_A || id == ID_SPEED_B) begin
				if (len >= 4) begin
					speed_rpm = {b[4], b[5][7:1]};
					supply_volts = {b[0], 1'b0};
					fb.kind = KIND_SPEED;
					// A full speed frame also carries torque and the diagnostic byte pair.
					if (len >= 8) begin
						raw11 = {b[2][2:0], b[3]};
						primary = int'($signed(raw11)) * TORQUE_STEP + torque_bias;
						magnitude = (primary < 0) ? -primary : primary;
						torque_centi = (magnitude <= TORQUE_CAP) ? primary : legacy_centi(data);
						speed_diag = {b[7], b[6]};
						kind_counters[CNT_TORQUE]++;
						fb.kind = KIND_SPEED_TORQUE;
					end
					kind_counters[CNT_SPEED]++;
					fb.count = kind_counters[CNT_SPEED];
				end
			end else if (id == ID_TORQUE_A || id == ID_TORQUE_B) begin
				if (len >= 4) begin
					torque_centi = legacy_centi(data);
					kind_counters[CNT_TORQUE]++;
					fb.count = kind_counters[CNT_TORQUE];
					fb.kind = KIND_TORQUE;
				end
			end else if (id == ID_TEMPS_A || id == ID_TEMPS_B) begin
				temps_hit = (len >= 3);
			end else if (id == ID_TEMPS_V && temps_variant_on) begin
				temps_hit = (len >= 4);
				first = 1;
			end else if (id == ID_STATUS_A || id == ID_STATUS_B) begin
				if (len >= 1) begin
					status_bits = b[0][3:0];
					kind_counters[CNT_STATUS]++;
					fb.count = kind_counters[CNT_STATUS];
					fb.kind = KIND_STATUS;
				end
			end

			// Temperature bytes carry a forty degree offset.
			if (temps_hit) begin
				for (int i = 0; i < 3; i++)
					celsius[i] = {1'b0, b[first+i]} - TEMP_OFFSET;
				kind_counters[CNT_TEMPS]++;
				fb.count = kind_counters[CNT_TEMPS];
				fb.kind = KIND_TEMPS;
			end

			fb.rpm = speed_rpm;
			fb.torque = torque_centi[21:0];
			fb.volts = supply_volts;
			fb.inverter_c = celsius[0];
			fb.stator_c = celsius[1];
			fb.coolant_c = celsius[2];
			fb.flags = status_bits;
			fb.rolling_clock = speed_diag[1:0];
			fb.error_code = speed_diag[7:2];
			fb.crc = speed_diag[15:8];
			expected_feedback.push_back(fb);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [2:0] kind, logic [OUT_W-1:0] word);
			feedback_t fb;
			if (expected_feedback.size() == 0) begin
				$error("result word with no frame waiting: kind %0h", kind);
				mismatches++;
				return;
			end
			fb = expected_feedback.pop_front();
			compare("frame_kind", fb.kind, kind);
			compare("motor_rpm", fb.rpm, word[14:0]);
			compare("torque_centi_nm", fb.torque, word[36:15]);
			compare("input_volts", fb.volts, word[45:37]);
			compare("inverter_celsius", fb.inverter_c, word[54:46]);
			compare("stator_celsius", fb.stator_c, word[63:55]);
			compare("coolant_celsius", fb.coolant_c, word[72:64]);
			compare("status_flags", fb.flags, word[76:73]);
			compare("motor_clock", fb.rolling_clock, word[78:77]);
			compare("motor_errors", fb.error_code, word[84:79]);
			compare("speed_crc_byte", fb.crc, word[92:85]);
			compare("kind_count", fb.count, word[124:93]);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [2:0]       m_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = 1'b0;
	logic [8:0]       cfg_data = '0;

	feedback_scoreboard board;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	inverter_can_frame_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: checks every word taken, stalls at random, and on request holds
	// off for a long stretch so that the block backs up into its input.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata);
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	// Offer one frame, with random idle cycles ahead of it, and note it once taken.
	task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, data, len, id};
		do @(posedge clk); while (!s_tready);
		board.note_frame(id, len, data);
	endtask

	// Stop offering frames and wait until every expected word has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.feedback_pending() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back; the block must be idle.
	task automatic apply_settings(bit en, int bias);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TEMPS_EN;
		cfg_data <= {8'd0, en};
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(REG_TEMPS_EN, {8'd0, en});
		cfg_index <= REG_TORQUE_BIAS;
		cfg_data <= bias[8:0];
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(REG_TORQUE_BIAS, bias[8:0]);
		cfg_valid <= 1'b0;
	endtask

	// Mostly frames with known identifiers and full length; the rest is noise.
	task automatic random_frame(output logic [10:0] id, output logic [3:0] len,
			output logic [63:0] data);
		logic [10:0] raw11;
		id = ($urandom_range(99) < 85) ? KNOWN_IDS[$urandom_range(8)] : 11'($urandom);
		len = ($urandom_range(99) < 60) ? 4'd8 : 4'($urandom_range(15));
		data = {$urandom, $urandom};
		// Push the speed frame torque field toward the plausibility limit.
		if ($urandom_range(7) == 0) begin
			raw11 = 11'($urandom_range(95) + 976);
			data[18:16] = raw11[10:8];
			data[31:24] = raw11[7:0];
		end
		// Zero words steer the old style torque pick to its other branch.
		if ($urandom_range(9) == 0)
			data[31:16] = 16'd0;
		if ($urandom_range(19) == 0)
			data[15:0] = 16'd0;
	endtask

	initial begin
		logic [10:0] id;
		logic [3:0]  len;
		logic [63:0] data;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames with the reset settings written explicitly.
		apply_settings(1'b0, -64);
		send_frame(ID_SPEED_A, 4'd8, 64'h0);
		send_frame(ID_SPEED_B, 4'd8, 64'hFFFFFFFF_FFFFFFFF);
		send_frame(ID_SPEED_A, 4'd8, 64'h00000000_FF030000);
		send_frame(ID_SPEED_B, 4'd8, 64'h00000000_00040000);
		send_frame(ID_SPEED_A, 4'd4, 64'h0000FE7F_000000FF);
		send_frame(ID_SPEED_A, 4'd4, 64'h00000180_00000000);
		send_frame(ID_SPEED_A, 4'd3, 64'h12345678_9ABCDEF0);
		send_frame(ID_SPEED_B, 4'd0, 64'h12345678_9ABCDEF0);
		send_frame(ID_SPEED_A, 4'd15, 64'hA5C3FE7F_FF0100FF);
		send_frame(ID_TORQUE_A, 4'd4, 64'h00000000_00008000);
		send_frame(ID_TORQUE_B, 4'd8, 64'h00000000_7FFF1234);
		send_frame(ID_TORQUE_A, 4'd8, 64'h0);
		send_frame(ID_TORQUE_B, 4'd3, 64'hFFFFFFFF_FFFFFFFF);
		send_frame(ID_TEMPS_A, 4'd3, 64'h00000000_0028FF00);
		send_frame(ID_TEMPS_B, 4'd2, 64'h00000000_00FFFFFF);
		send_frame(ID_TEMPS_V, 4'd8, 64'h00000000_FF2800AA);
		send_frame(ID_STATUS_A, 4'd1, 64'h00000000_000000FF);
		send_frame(ID_STATUS_B, 4'd0, 64'h00000000_0000000F);
		send_frame(ID_STATUS_B, 4'd8, 64'hFFFFFFFF_FFFFFF5A);
		send_frame(11'h7FF, 4'd8, 64'hFFFFFFFF_FFFFFFFF);
		send_frame(11'h000, 4'd8, 64'h0);
		wait_idle();

		// Torque exactly at the limit, then the enabled variant temperature frame.
		apply_settings(1'b1, 0);
		send_frame(ID_SPEED_A, 4'd8, 64'h00000000_E8030000);
		send_frame(ID_SPEED_B, 4'd8, 64'h00000000_18040000);
		wait_idle();
		apply_settings(1'b1, -200);
		send_frame(ID_SPEED_A, 4'd8, 64'h00000000_E8030000);
		send_frame(ID_SPEED_A, 4'd8, 64'h00000000_18040000);
		send_frame(ID_TEMPS_V, 4'd4, 64'h00000000_FF2800AA);
		send_frame(ID_TEMPS_V, 4'd3, 64'h00000000_00FFFF11);
		wait_idle();

		// Random phases, each with its own settings; the first two add random idle cycles.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 87;
					apply_settings(1'b1, 200);
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 12;
					apply_settings(1'b0, -200);
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					apply_settings(1'b1, 0);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					apply_settings(1'($urandom_range(1)), int'($urandom_range(400)) - 200);
				end
			endcase
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				if (phase == 2 && n == 16)
					hold_request = 1'b1;
				random_frame(id, len, data);
				send_frame(id, len, data);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
design/ifdc_pkg.sv
design/inverter_can_frame_decoder_core.sv
tb/sv/testbench.sv
